@@ hdl/spq_pkg.sv @@
// Shared types and constants for the stable priority queue with stock counter.
package spq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int IDX_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = 5;
  localparam int ID_W        = 16;
  localparam int LVL_W       = 2;
  localparam int STOCK_W     = 16;

  localparam logic [LVL_W-1:0] LVL_NONE   = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOWEST = 2'd3;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_SERVE  = 2'd1,
    KIND_CANCEL = 2'd2,
    KIND_NONE   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOSTOCK  = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_INS_HEAD,
    S_REM,
    S_EMIT
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [ID_W-1:0]   requester_id;
    logic [LVL_W-1:0]  priority_level;
  } in_word_t;

  typedef struct packed {
    status_t            status;
    logic [ID_W-1:0]    served_id;
    logic [LVL_W-1:0]   served_level;
    logic [STOCK_W-1:0] stock_left;
    logic [CNT_W-1:0]   waiting_count;
  } out_word_t;

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [ID_W-1:0]  id;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

@@ hdl/spq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/stable_priority_queue_with_stock.sv @@
// Stable priority queue of requester ids with a stock counter, top level.
// Insert works by a tail-to-head shift walk over the entry RAM, one entry a cycle;
// serve and cancel work by a head-to-tail walk over the waiting entries; rejected
// items go straight to the result. One word at a time.
// The result word sits in an output register, so the next word is taken while it waits.
// Reset (synchronous, rst_n low) empties the queue and clears the stock counter.
module stable_priority_queue_with_stock
  import spq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               cfg_we,
  input  logic [STOCK_W-1:0] cfg_data
);

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [STOCK_W-1:0] stock_r, stock_nxt;
  kind_t              kind_r, kind_nxt;
  logic [ID_W-1:0]    id_r, id_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               found_r, found_nxt;
  out_word_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_data_r, out_data_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata;
  logic [IDX_W-1:0]   ram_raddr;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             rd_entry;

  logic [CNT_W-1:0]   count_m1;
  logic [LVL_W-1:0]   in_lvl;
  logic               is_last;
  logic               hit;

  spq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd_entry = entry_t'(ram_rdata);
  assign count_m1 = count_r - CNT_W'(1);
  assign in_lvl   = (in_data.priority_level == LVL_NONE) ? LVL_LOWEST
                                                         : in_data.priority_level;
  assign is_last  = ({1'b0, idx_r} == count_m1);
  assign hit      = (kind_r == KIND_SERVE) || (rd_entry.id == id_r);

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      stock_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      stock_r     <= stock_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    id_r       <= id_nxt;
    lvl_r      <= lvl_nxt;
    idx_r      <= idx_nxt;
    found_r    <= found_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    stock_nxt     = stock_r;
    kind_nxt      = kind_r;
    id_nxt        = id_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r & out_stall;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    case (state_r)
      S_IDLE: begin
        ram_raddr = (in_data.kind == KIND_INSERT) ? count_m1[IDX_W-1:0] : '0;
        if (in_valid) begin
          kind_nxt  = in_data.kind;
          id_nxt    = in_data.requester_id;
          lvl_nxt   = in_lvl;
          found_nxt = 1'b0;
          res_nxt   = '{status: ST_OK, served_id: '0, served_level: LVL_NONE,
                        stock_left: stock_r, waiting_count: count_r};
          state_nxt = S_EMIT;
          case (in_data.kind)
            KIND_INSERT: begin
              if (count_r == CNT_W'(QUEUE_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else if (count_r == '0) begin
                ram_we                = 1'b1;
                ram_waddr             = '0;
                ram_wdata             = {in_lvl, in_data.requester_id};
                count_nxt             = count_r + CNT_W'(1);
                res_nxt.waiting_count = count_nxt;
              end else begin
                idx_nxt   = count_m1[IDX_W-1:0];
                state_nxt = S_INS;
              end
            end
            KIND_SERVE: begin
              if (stock_r == '0) begin
                res_nxt.status = ST_NOSTOCK;
              end else if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_REM;
              end
            end
            KIND_CANCEL: begin
              if (count_r == '0) begin
                res_nxt.status = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_REM;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_INS: begin
        ram_raddr = idx_r - IDX_W'(1);
        ram_we    = 1'b1;
        ram_waddr = idx_r + IDX_W'(1);
        if (rd_entry.level <= lvl_r) begin
          ram_wdata             = {lvl_r, id_r};
          count_nxt             = count_r + CNT_W'(1);
          res_nxt.waiting_count = count_nxt;
          state_nxt             = S_EMIT;
        end else begin
          ram_wdata = ram_rdata;
          if (idx_r == '0) begin
            state_nxt = S_INS_HEAD;
          end else begin
            idx_nxt = idx_r - IDX_W'(1);
          end
        end
      end

      S_INS_HEAD: begin
        ram_we                = 1'b1;
        ram_waddr             = '0;
        ram_wdata             = {lvl_r, id_r};
        count_nxt             = count_r + CNT_W'(1);
        res_nxt.waiting_count = count_nxt;
        state_nxt             = S_EMIT;
      end

      S_REM: begin
        ram_raddr = idx_r + IDX_W'(1);
        ram_we    = found_r;
        ram_waddr = idx_r - IDX_W'(1);
        ram_wdata = ram_rdata;
        if (!found_r && hit) begin
          found_nxt = 1'b1;
          if (kind_r == KIND_SERVE) begin
            res_nxt.served_id    = rd_entry.id;
            res_nxt.served_level = rd_entry.level;
          end
        end
        if (is_last) begin
          state_nxt = S_EMIT;
          if (found_r || hit) begin
            count_nxt             = count_m1;
            res_nxt.waiting_count = count_m1;
            if (kind_r == KIND_SERVE) begin
              stock_nxt          = stock_r - STOCK_W'(1);
              res_nxt.stock_left = stock_nxt;
            end
          end else begin
            res_nxt.status = ST_NOTFOUND;
          end
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (cfg_we) begin
      stock_nxt = cfg_data;
    end
  end

endmodule

@@ hdl/spq_checker.sv @@
// Port-level assertions for the stable priority queue, bound to the top level.
module spq_checker
  import spq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.waiting_count <= CNT_W'(QUEUE_DEPTH))
    else $error("waiting count beyond queue depth");

  a_no_serve_on_error: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.served_id == '0 && out_data.served_level == LVL_NONE)
    else $error("served fields set on failed word");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second word taken while one is in work");

endmodule

bind stable_priority_queue_with_stock spq_checker u_spq_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ tb/stable_priority_queue_with_stock_test.sv @@
// Self-checking testbench for the stable priority queue with stock counter.
module stable_priority_queue_with_stock_test;
  timeunit 1ns;
  timeprecision 1ps;
  import spq_pkg::*;

  localparam int CLK_PERIOD    = 12;
  localparam int BATCHES       = 10;
  localparam int BATCH_WORDS   = 125;
  localparam int LONG_HOLD     = 150;
  localparam int SETTLE_CYCLES = QUEUE_DEPTH + 6;
  localparam int TIMEOUT_NS    = 5_000_000;

  typedef struct packed {
    logic               load_stock;
    logic [STOCK_W-1:0] stock_val;
    in_word_t           word;
    logic [4:0]         reps;
    logic               typed;
    out_word_t          want;
  } dir_row_t;

  localparam int DIR_ROWS = 21;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, 16'h0000, '{KIND_SERVE, 16'h0000, 2'd0}, 5'd1, 1'b1,
      '{ST_NOSTOCK, 16'h0000, 2'd0, 16'd0, 5'd0}},
    '{1'b0, 16'h0000, '{KIND_CANCEL, 16'h0000, 2'd0}, 5'd1, 1'b1,
      '{ST_NOTFOUND, 16'h0000, 2'd0, 16'd0, 5'd0}},
    '{1'b0, 16'h0000, '{KIND_NONE, 16'hFFFF, 2'd3}, 5'd1, 1'b1,
      '{ST_OK, 16'h0000, 2'd0, 16'd0, 5'd0}},
    '{1'b1, 16'd2, '{KIND_NONE, 16'h0000, 2'd0}, 5'd0, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_SERVE, 16'hFFFF, 2'd3}, 5'd1, 1'b1,
      '{ST_EMPTY, 16'h0000, 2'd0, 16'd2, 5'd0}},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'hFFFF, 2'd3}, 5'd1, 1'b1,
      '{ST_OK, 16'h0000, 2'd0, 16'd2, 5'd1}},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'h0000, 2'd0}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'h1234, 2'd1}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'h5555, 2'd2}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'hAAAA, 2'd1}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'h8001, 2'd2}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_CANCEL, 16'hFFFF, 2'd0}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_CANCEL, 16'h7777, 2'd1}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_SERVE, 16'h0000, 2'd0}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_SERVE, 16'h0000, 2'd0}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_SERVE, 16'h0000, 2'd0}, 5'd1, 1'b0, '0},
    '{1'b1, 16'hFFFF, '{KIND_NONE, 16'h0000, 2'd0}, 5'd0, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'h0100, 2'd3}, 5'd13, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_INSERT, 16'hBEEF, 2'd1}, 5'd1, 1'b1,
      '{ST_FULL, 16'h0000, 2'd0, 16'hFFFF, 5'd16}},
    '{1'b0, 16'h0000, '{KIND_SERVE, 16'h0000, 2'd0}, 5'd1, 1'b0, '0},
    '{1'b0, 16'h0000, '{KIND_CANCEL, 16'h010C, 2'd0}, 5'd1, 1'b0, '0}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_word_t           in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_word_t          out_data;
  logic               cfg_we = 1'b0;
  logic [STOCK_W-1:0] cfg_data = '0;

  logic [ID_W-1:0]    held_id [QUEUE_DEPTH];
  logic [LVL_W-1:0]   held_lvl [QUEUE_DEPTH];
  int                 held_count = 0;
  logic [STOCK_W-1:0] stock_now = '0;
  out_word_t          awaited_words [$];

  int err_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int holds_asked = 0;
  int holds_granted = 0;
  int hold_left = 0;

  stable_priority_queue_with_stock uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever begin
      #(CLK_PERIOD / 2.0) clk = ~clk;
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t ns mismatch %s: got %0h want %0h", $time, what, got, want);
    err_count++;
  endtask

  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held_count; i++) begin
      held_id[i]  = held_id[i+1];
      held_lvl[i] = held_lvl[i+1];
    end
    held_count--;
  endfunction

  function automatic out_word_t apply_request(in_word_t w);
    out_word_t        r;
    logic [LVL_W-1:0] lvl;
    int               pos;
    r = '0;
    r.status = ST_OK;
    case (w.kind)
      KIND_INSERT: begin
        lvl = (w.priority_level == LVL_NONE) ? LVL_LOWEST : w.priority_level;
        if (held_count >= QUEUE_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          pos = 0;
          while (pos < held_count && held_lvl[pos] <= lvl) pos++;
          for (int i = held_count; i > pos; i--) begin
            held_id[i]  = held_id[i-1];
            held_lvl[i] = held_lvl[i-1];
          end
          held_id[pos]  = w.requester_id;
          held_lvl[pos] = lvl;
          held_count++;
        end
      end
      KIND_SERVE: begin
        if (stock_now == '0) begin
          r.status = ST_NOSTOCK;
        end else if (held_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.served_id    = held_id[0];
          r.served_level = held_lvl[0];
          drop_entry(0);
          stock_now--;
        end
      end
      KIND_CANCEL: begin
        r.status = ST_NOTFOUND;
        for (int i = 0; i < held_count; i++) begin
          if (held_id[i] == w.requester_id) begin
            drop_entry(i);
            r.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    r.stock_left    = stock_now;
    r.waiting_count = CNT_W'(held_count);
    return r;
  endfunction

  function automatic in_word_t random_word(bit filling, logic [ID_W-1:0] base);
    in_word_t w;
    int       pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) w.kind = KIND_NONE;
    else if (pick < (filling ? 70 : 30)) w.kind = KIND_INSERT;
    else if (pick < (filling ? 82 : 75)) w.kind = KIND_SERVE;
    else w.kind = KIND_CANCEL;
    if ($urandom_range(0, 3) == 0) w.requester_id = ID_W'($urandom);
    else w.requester_id = base ^ ID_W'($urandom_range(0, 7));
    w.priority_level = LVL_W'($urandom_range(0, 3));
    return w;
  endfunction

  task automatic send_word(in_word_t word, logic typed, out_word_t want);
    out_word_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= word;
    do @(posedge clk); while (in_stall);
    pred = apply_request(word);
    awaited_words.push_back(typed ? want : pred);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (awaited_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_stock(logic [STOCK_W-1:0] value);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we   <= 1'b0;
    stock_now = value;
  endtask

  initial begin
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (holds_granted < holds_asked) begin
        holds_granted++;
        hold_left = LONG_HOLD;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (awaited_words.size() == 0) begin
        report_mismatch("unexpected word", 64'(out_data), '0);
      end else begin
        want = awaited_words.pop_front();
        if (out_data.status !== want.status)
          report_mismatch("status", 64'(out_data.status), 64'(want.status));
        if (out_data.served_id !== want.served_id)
          report_mismatch("served_id", 64'(out_data.served_id),
                          64'(want.served_id));
        if (out_data.served_level !== want.served_level)
          report_mismatch("served_level", 64'(out_data.served_level),
                          64'(want.served_level));
        if (out_data.stock_left !== want.stock_left)
          report_mismatch("stock_left", 64'(out_data.stock_left),
                          64'(want.stock_left));
        if (out_data.waiting_count !== want.waiting_count)
          report_mismatch("waiting_count", 64'(out_data.waiting_count),
                          64'(want.waiting_count));
      end
    end
  end

  initial begin
    in_word_t        w;
    bit              filling;
    logic [ID_W-1:0] pool_base;
    filling = 1'b1;
    send_idle_pct = 6;
    recv_idle_pct = 69;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIR_TABLE[r]) begin
      if (DIR_TABLE[r].load_stock) begin
        wait_drained();
        load_stock(DIR_TABLE[r].stock_val);
      end else begin
        for (int k = 0; k < DIR_TABLE[r].reps; k++) begin
          w = DIR_TABLE[r].word;
          w.requester_id = w.requester_id + ID_W'(k);
          send_word(w, DIR_TABLE[r].typed, DIR_TABLE[r].want);
        end
      end
    end

    for (int b = 0; b < BATCHES; b++) begin
      if (b < 4) begin
        send_idle_pct = 6;
        recv_idle_pct = 69;
      end else if (b < 7) begin
        send_idle_pct = 69;
        recv_idle_pct = 6;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      wait_drained();
      case (b % 4)
        0: load_stock(16'hFFFF);
        1: load_stock(STOCK_W'($urandom_range(20, 60)));
        2: load_stock(16'h0000);
        default: load_stock(STOCK_W'($urandom));
      endcase
      pool_base = ID_W'($urandom);
      for (int n = 0; n < BATCH_WORDS; n++) begin
        if ((b == 1 || b == 8) && n == 30) holds_asked++;
        if ($urandom_range(0, 39) == 0) filling = !filling;
        send_word(random_word(filling, pool_base), 1'b0, '0);
      end
    end

    wait_drained();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
